// ===== sv/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/plcr_pkg.sv =====
package plcr_pkg;
   localparam int DefaultEntries = 16;
   localparam int KeyW = 32;
   localparam int ChW = 8;
   localparam int AlphaW = 9;
   localparam int ColW = 3 * ChW + AlphaW;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_COLOUR  = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_INSERT  = 3'd2,
      ST_DUP     = 3'd3,
      ST_FULL    = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   localparam logic CSR_RGB = 1'b0;
   localparam logic CSR_ALPHA = 1'b1;

   // queued command from front to back
   typedef struct packed {
      op_type           op;
      logic [KeyW-1:0]  value;
      logic [ColW-1:0]  colour;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_SHIFT,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } bk_state_type;
endpackage

// ===== sv/plcr_front.sv =====
// Accepts commands, clamps alpha, and holds one queued beat.
module plcr_front
   import plcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [1:0]  req_operation,
   input  logic signed [31:0] req_data_value,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic signed [8:0] req_in_alpha,
   output logic        q_valid,
   output cmd_type     q_cmd,
   input  logic        q_pop
);
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic [8:0] alpha;

   assign req_busy = valid_ff;
   assign alpha = (req_in_alpha < -9'sd1) ? 9'h1ff : req_in_alpha;

   always_comb begin
      cmd_in = cmd_ff;
      valid_in = valid_ff & ~q_pop;
      if (req_start && !valid_ff) begin
         valid_in = 1'b1;
         cmd_in.op = op_type'(req_operation);
         cmd_in.value = req_data_value;
         cmd_in.colour = {req_in_red, req_in_green, req_in_blue, alpha};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

   assign q_valid = valid_ff;
   assign q_cmd = cmd_ff;
endmodule

// ===== sv/plcr_back.sv =====
// Table, scan, insert shift and interpolation with serial divide.
module plcr_back
   import plcr_pkg::*;
#(
   parameter int TABLE_ENTRIES = DefaultEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        rgb_en,
   input  logic        alpha_en,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic signed [8:0] rsp_out_alpha,
   output logic [2:0]  rsp_status
);
   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   // numerator magnitude < 2^(33+10); quotient fits 44 bits
   localparam int NW = 45;
   localparam int QW = 44;

   bk_state_type state_ff, state_in;
   logic [KeyW-1:0] key_ff [TABLE_ENTRIES];
   logic [ColW-1:0] col_ff [TABLE_ENTRIES];
   logic [CW-1:0] cnt_ff;
   cmd_type cmd_ff;
   logic [IW-1:0] idx_ff;      // scan / shift index
   logic [CW-1:0] pos_ff;      // insert position / lower entry count
   logic dup_ff;
   logic full_ff;              // table was full when the command started
   logic [5:0] step_ff;
   logic [NW-1:0] rem_ff [4];
   logic [QW-1:0] quo_ff [4];
   logic neg_ff [4];
   logic [32:0] den_ff;
   logic signed [9:0] lo_c [4];
   logic signed [9:0] hi_c [4];
   logic signed [32:0] dk, dv;
   logic [IW-1:0] lo_i, hi_i;
   logic has_hi;
   logic signed [33:0] v_s;
   logic signed [33:0] k_s;

   logic        out_v_ff;
   logic [7:0]  o_r_ff, o_g_ff, o_b_ff;
   logic [8:0]  o_a_ff;
   logic [2:0]  o_s_ff;

   always_comb begin
      v_s = 34'(signed'(cmd_ff.value));
      k_s = 34'(signed'(key_ff[idx_ff]));
   end

   // lower index: entries with key <= v counted in pos_ff
   assign lo_i = (pos_ff == '0) ? '0 : IW'(pos_ff - CW'(1));
   assign hi_i = IW'(lo_i + IW'(1));
   assign has_hi = (CW'(lo_i) + CW'(1)) < cnt_ff;
   assign dk = 33'(signed'(key_ff[hi_i])) - 33'(signed'(key_ff[lo_i]));
   assign dv = 33'(signed'(cmd_ff.value)) - 33'(signed'(key_ff[lo_i]));

   always_comb begin
      lo_c[0] = 10'(col_ff[lo_i][32:25]);
      lo_c[1] = 10'(col_ff[lo_i][24:17]);
      lo_c[2] = 10'(col_ff[lo_i][16:9]);
      lo_c[3] = 10'(signed'(col_ff[lo_i][8:0]));
      hi_c[0] = 10'(col_ff[hi_i][32:25]);
      hi_c[1] = 10'(col_ff[hi_i][24:17]);
      hi_c[2] = 10'(col_ff[hi_i][16:9]);
      hi_c[3] = 10'(signed'(col_ff[hi_i][8:0]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (q_valid) begin
            if (q_cmd.op == OP_CLEAR) state_in = BK_DONE;
            else state_in = BK_SCAN;
         end
         BK_SCAN: if (CW'(idx_ff) + CW'(1) >= cnt_ff || cnt_ff == '0) begin
            if (cmd_ff.op == OP_INSERT) state_in = BK_SHIFT;
            else state_in = BK_MUL;
         end
         BK_SHIFT: if (CW'(idx_ff) <= pos_ff || dup_ff || cnt_ff == CW'(TABLE_ENTRIES))
            state_in = BK_DONE;
         BK_MUL: state_in = BK_DIV;
         BK_DIV: if (step_ff == 6'd0) state_in = BK_DONE;
         BK_DONE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   assign q_pop = (state_ff == BK_DONE);

   // channel saturation helpers
   function automatic logic [7:0] sat8(input logic neg, input logic [QW-1:0] q);
      if (neg) return (q == '0) ? 8'd0 : 8'd0;
      return (q > QW'(255)) ? 8'd255 : q[7:0];
   endfunction
   function automatic logic [8:0] sat9(input logic neg, input logic [QW-1:0] q);
      if (neg) return (q == '0) ? 9'd0 : 9'h1ff;
      return (q > QW'(255)) ? 9'd255 : q[8:0];
   endfunction

   logic signed [NW-1:0] num [4];
   logic [NW-1:0] sub [4];
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         num[c] = NW'(lo_c[c]) * NW'(dk) + NW'(hi_c[c] - lo_c[c]) * NW'(dv);
         sub[c] = {rem_ff[c][NW-2:0], quo_ff[c][QW-1]} - NW'(den_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= 1'b0;
         unique case (state_ff)
            BK_IDLE: begin
               cmd_ff <= q_cmd;
               idx_ff <= '0;
               pos_ff <= '0;
               dup_ff <= 1'b0;
               full_ff <= (cnt_ff == CW'(TABLE_ENTRIES));
            end
            BK_SCAN: begin
               if (cnt_ff != '0) begin
                  if (cmd_ff.op == OP_INSERT) begin
                     if (k_s == v_s) dup_ff <= 1'b1;
                     if (k_s < v_s) pos_ff <= CW'(idx_ff) + CW'(1);
                  end else if (k_s <= v_s) pos_ff <= CW'(idx_ff) + CW'(1);
               end
               if (CW'(idx_ff) + CW'(1) >= cnt_ff || cnt_ff == '0)
                  idx_ff <= (cnt_ff == CW'(TABLE_ENTRIES)) ? IW'(TABLE_ENTRIES - 1)
                            : cnt_ff[IW-1:0];
               else idx_ff <= IW'(idx_ff + IW'(1));
            end
            BK_SHIFT: begin
               if (!dup_ff && cnt_ff != CW'(TABLE_ENTRIES)) begin
                  if (CW'(idx_ff) > pos_ff) begin
                     key_ff[idx_ff] <= key_ff[IW'(idx_ff - IW'(1))];
                     col_ff[idx_ff] <= col_ff[IW'(idx_ff - IW'(1))];
                     idx_ff <= IW'(idx_ff - IW'(1));
                  end else begin
                     key_ff[idx_ff] <= cmd_ff.value;
                     col_ff[idx_ff] <= cmd_ff.colour;
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end
            end
            BK_MUL: begin
               den_ff <= dk;
               step_ff <= 6'(QW - 1);
               for (int c = 0; c < 4; c++) begin
                  neg_ff[c] <= num[c][NW-1];
                  quo_ff[c] <= QW'(num[c][NW-1] ? -num[c] : num[c]);
                  rem_ff[c] <= '0;
               end
            end
            BK_DIV: begin
               step_ff <= step_ff - 6'd1;
               for (int c = 0; c < 4; c++) begin
                  if (!sub[c][NW-1]) begin
                     rem_ff[c] <= sub[c];
                     quo_ff[c] <= {quo_ff[c][QW-2:0], 1'b1};
                  end else begin
                     rem_ff[c] <= {rem_ff[c][NW-2:0], quo_ff[c][QW-1]};
                     quo_ff[c] <= {quo_ff[c][QW-2:0], 1'b0};
                  end
               end
            end
            BK_DONE: begin
               out_v_ff <= 1'b1;
               o_r_ff <= '0; o_g_ff <= '0; o_b_ff <= '0; o_a_ff <= '0;
               case (cmd_ff.op)
                  OP_CLEAR: begin
                     o_s_ff <= ST_CLEARED;
                     cnt_ff <= '0;
                  end
                  OP_INSERT:
                     o_s_ff <= dup_ff ? ST_DUP : (full_ff ? ST_FULL : ST_INSERT);
                  default: begin
                     if (cnt_ff == '0) o_s_ff <= ST_EMPTY;
                     else begin
                        o_s_ff <= ST_COLOUR;
                        o_r_ff <= (rgb_en && has_hi) ? sat8(neg_ff[0], quo_ff[0])
                                  : col_ff[lo_i][32:25];
                        o_g_ff <= (rgb_en && has_hi) ? sat8(neg_ff[1], quo_ff[1])
                                  : col_ff[lo_i][24:17];
                        o_b_ff <= (rgb_en && has_hi) ? sat8(neg_ff[2], quo_ff[2])
                                  : col_ff[lo_i][16:9];
                        o_a_ff <= (alpha_en && has_hi) ? sat9(neg_ff[3], quo_ff[3])
                                  : col_ff[lo_i][8:0];
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_red = o_r_ff;
   assign rsp_out_green = o_g_ff;
   assign rsp_out_blue = o_b_ff;
   assign rsp_out_alpha = o_a_ff;
   assign rsp_status = o_s_ff;
endmodule

// ===== sv/piecewise_linear_colour_ramp_unit.sv =====
// Piecewise-linear colour ramp.
// Command channel: raise start while busy is low; the beat carries
// the operation (lookup, insert, clear), the value or key and the colour.
// Result channel: rsp_valid is high for one cycle with colour and status;
// the receiver cannot stall it, so it must sample every strobe.
// A one-beat command queue sits in front; the back end works one command
// at a time and retires the queued beat in the cycle before the strobe, so
// busy stays high from the accepting edge until the strobe starts and the
// next beat can be taken at the edge that ends the strobe.
// Steps from the accepting edge to the strobe: lookup runs an idle step,
// a scan of the entries, a multiply, a 44-step restoring divide run for
// the four channels in parallel and an output step; insert runs the idle
// step, the scan, a shift of the entries above the insert point (no move
// for a duplicate or a full table) and the output step; clear runs the
// idle and output steps. One command in flight: a new beat waits for the strobe.
// Reset empties the table and the queue and clears both control bits.
// csr_write_enable with csr_index 0 sets RGB interpolation, 1 alpha.
`include "assert_macros.svh"
module piecewise_linear_colour_ramp_unit
   import plcr_pkg::*;
#(
   parameter int TABLE_ENTRIES = DefaultEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic signed [31:0] req_data_value,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic signed [8:0] req_in_alpha,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic signed [8:0] rsp_out_alpha,
   output logic [2:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);
   logic rgb_ff, alpha_ff;
   logic q_valid, q_pop;
   cmd_type q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb_ff <= 1'b0;
         alpha_ff <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_RGB) rgb_ff <= csr_write_data;
         if (csr_index == CSR_ALPHA) alpha_ff <= csr_write_data;
      end
   end

   plcr_front u_front (
      .clock, .reset,
      .req_start(start), .req_busy(busy),
      .req_operation, .req_data_value, .req_in_red, .req_in_green,
      .req_in_blue, .req_in_alpha,
      .q_valid, .q_cmd, .q_pop
   );

   plcr_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset,
      .rgb_en(rgb_ff), .alpha_en(alpha_ff),
      .q_valid, .q_cmd, .q_pop,
      .rsp_valid, .rsp_out_red, .rsp_out_green, .rsp_out_blue,
      .rsp_out_alpha, .rsp_status
   );

   // retiring the queued command always gives a result beat
   `ASSERT_IMPL(a_rsp_pops, clock, reset, q_pop |=> rsp_valid, "result missing")
   // no pop without a command in the queue
   `ASSERT_IMPL(a_pop_valid, clock, reset, q_pop |-> q_valid, "pop of empty queue")
endmodule
